[rtl/msd_pkg.sv]
// Package: shared constants, result type and Morse lookup table of the stream decoder.
`timescale 1ns / 1ps
package msd_pkg;

	localparam int MAX_CODE_LEN_DEF = 6;

	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_DASH = 8'h2D;
	localparam logic [6:0] CHAR_SPACE = 7'd32;
	localparam logic [6:0] CHAR_NL    = 7'd10;
	localparam logic [6:0] CHAR_NONE  = 7'd0;
	localparam logic [1:0] WORD_GAP_RST = 2'd2;

	typedef struct packed {
		logic [6:0] ch;
		logic       unk;
		logic       last;
	} result_t;

	// Returns {found, ascii}; bits hold the elements first element high, dash = 1.
	function automatic logic [7:0] morse_lookup(input logic [3:0] len, input logic [7:0] bits);
		logic [7:0] r;
		r = 8'h00;
		case ({len, bits})
			{4'd2, 8'b00000001}: r = {1'b1, 7'h41};
			{4'd4, 8'b00001000}: r = {1'b1, 7'h42};
			{4'd4, 8'b00001010}: r = {1'b1, 7'h43};
			{4'd3, 8'b00000100}: r = {1'b1, 7'h44};
			{4'd1, 8'b00000000}: r = {1'b1, 7'h45};
			{4'd4, 8'b00000010}: r = {1'b1, 7'h46};
			{4'd3, 8'b00000110}: r = {1'b1, 7'h47};
			{4'd4, 8'b00000000}: r = {1'b1, 7'h48};
			{4'd2, 8'b00000000}: r = {1'b1, 7'h49};
			{4'd4, 8'b00000111}: r = {1'b1, 7'h4A};
			{4'd3, 8'b00000101}: r = {1'b1, 7'h4B};
			{4'd4, 8'b00000100}: r = {1'b1, 7'h4C};
			{4'd2, 8'b00000011}: r = {1'b1, 7'h4D};
			{4'd2, 8'b00000010}: r = {1'b1, 7'h4E};
			{4'd3, 8'b00000111}: r = {1'b1, 7'h4F};
			{4'd4, 8'b00000110}: r = {1'b1, 7'h50};
			{4'd4, 8'b00001101}: r = {1'b1, 7'h51};
			{4'd3, 8'b00000010}: r = {1'b1, 7'h52};
			{4'd3, 8'b00000000}: r = {1'b1, 7'h53};
			{4'd1, 8'b00000001}: r = {1'b1, 7'h54};
			{4'd3, 8'b00000001}: r = {1'b1, 7'h55};
			{4'd4, 8'b00000001}: r = {1'b1, 7'h56};
			{4'd3, 8'b00000011}: r = {1'b1, 7'h57};
			{4'd4, 8'b00001001}: r = {1'b1, 7'h58};
			{4'd4, 8'b00001011}: r = {1'b1, 7'h59};
			{4'd4, 8'b00001100}: r = {1'b1, 7'h5A};
			{4'd5, 8'b00011111}: r = {1'b1, 7'h30};
			{4'd5, 8'b00001111}: r = {1'b1, 7'h31};
			{4'd5, 8'b00000111}: r = {1'b1, 7'h32};
			{4'd5, 8'b00000011}: r = {1'b1, 7'h33};
			{4'd5, 8'b00000001}: r = {1'b1, 7'h34};
			{4'd5, 8'b00000000}: r = {1'b1, 7'h35};
			{4'd5, 8'b00010000}: r = {1'b1, 7'h36};
			{4'd5, 8'b00011000}: r = {1'b1, 7'h37};
			{4'd5, 8'b00011100}: r = {1'b1, 7'h38};
			{4'd5, 8'b00011110}: r = {1'b1, 7'h39};
			{4'd6, 8'b00010101}: r = {1'b1, 7'h2E};
			{4'd6, 8'b00110011}: r = {1'b1, 7'h2C};
			{4'd6, 8'b00001100}: r = {1'b1, 7'h3F};
			{4'd6, 8'b00011110}: r = {1'b1, 7'h27};
			{4'd6, 8'b00101011}: r = {1'b1, 7'h21};
			{4'd5, 8'b00010010}: r = {1'b1, 7'h2F};
			{4'd5, 8'b00010110}: r = {1'b1, 7'h28};
			{4'd6, 8'b00101101}: r = {1'b1, 7'h29};
			{4'd5, 8'b00001000}: r = {1'b1, 7'h26};
			{4'd6, 8'b00111000}: r = {1'b1, 7'h3A};
			{4'd6, 8'b00101010}: r = {1'b1, 7'h3B};
			{4'd5, 8'b00010001}: r = {1'b1, 7'h3D};
			{4'd5, 8'b00001010}: r = {1'b1, 7'h2B};
			{4'd6, 8'b00100001}: r = {1'b1, 7'h2D};
			{4'd6, 8'b00001101}: r = {1'b1, 7'h5F};
			{4'd6, 8'b00010010}: r = {1'b1, 7'h22};
			{4'd6, 8'b00011010}: r = {1'b1, 7'h40};
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

[rtl/msd_if.sv]
// Interfaces: input item channel and result channel of the stream decoder.
`timescale 1ns / 1ps
interface msd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_message;

	modport source (output valid, output in_char, output end_of_message, input ready);
	modport sink (input valid, input in_char, input end_of_message, output ready);
endinterface

interface msd_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       unknown_code;
	logic       last_of_run;

	modport source (output valid, output out_char, output unknown_code, output last_of_run,
		input ready);
	modport sink (input valid, input out_char, input unknown_code, input last_of_run,
		output ready);
endinterface

[rtl/msd_outq.sv]
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ch.ready is high.
`timescale 1ns / 1ps
module msd_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  msd_pkg::result_t  push0,
	input  msd_pkg::result_t  push1,
	output logic [2:0]        level,
	msd_out_if.source         out_ch
);
	import msd_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	result_t       slot_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [2:0]    cnt_q;
	logic          pop;

	assign pop = out_ch.valid && out_ch.ready;
	assign level = cnt_q;

	assign out_ch.valid        = cnt_q != 3'd0;
	assign out_ch.out_char     = slot_q[rp_q].ch;
	assign out_ch.unknown_code = slot_q[rp_q].unk;
	assign out_ch.last_of_run  = slot_q[rp_q].last;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			slot_q[wp_q] <= push0;
		end
		if (push_n == 2'd2) begin
			slot_q[wp_q + AW'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + AW'(push_n);
			rp_q  <= rp_q + AW'(pop);
			cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end
endmodule

[rtl/morse_stream_decoder_unit.sv]
// Top level: Morse stream decoder with state memory, step logic and result queue.
`timescale 1ns / 1ps
// Morse stream decoder. Each input item is one character byte: '.' and '-' are
// code elements, anything else is a separator, and end_of_message flushes any
// pending code word and emits a newline. A separator ending a code word gives
// the decoded ASCII character (0 with unknown_code for a code not in the table
// or longer than MAX_CODE_LEN); every word_gap separators in a row give a space.
// An item can cause zero, one or two results; last_of_run marks the final one.
// Rate: one item per cycle while the four-entry result queue has room; results
// leave at one per cycle while out_ch.ready is high, which limits a stream of
// two-result items. Results are registered in the result queue from stage-1
// registers loaded at accept. The decoder state sits in a one-entry memory read
// at accept and written back in the following cycle, with the write-back
// forwarded to the next item. word_gap (reset 2, value 0 acts as 1) is written
// by the user via cfg_we/cfg_wdata only while idle; the block does not check.
module morse_stream_decoder_unit #(
	parameter int MAX_CODE_LEN = msd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	msd_in_if.sink      in_ch,
	msd_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);
	import msd_pkg::*;

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

	typedef struct packed {
		logic [MAX_CODE_LEN-1:0] bits;
		logic [LEN_W-1:0]        len;
		logic                    ovf;
		logic [1:0]              gap;
	} state_t;

	// word gap register
	logic [1:0] word_gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_gap_q <= WORD_GAP_RST;
		end else if (cfg_we) begin
			word_gap_q <= cfg_wdata;
		end
	end

	// accept and stage 1 control
	logic       accept;
	logic       valid_s1;
	logic       fwd_s1;
	logic [7:0] char_s1;
	logic       eom_s1;
	logic [2:0] level;
	logic [1:0] n_res;
	logic [1:0] push_n;

	assign accept = in_ch.valid && in_ch.ready;
	// Hold off the next item unless the queue can absorb its two results.
	assign in_ch.ready = (level + 3'(push_n)) <= 3'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				// previous item writes back at this edge: its value is newer than the read
				fwd_s1 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= in_ch.in_char;
			eom_s1  <= in_ch.end_of_message;
		end
	end

	// state memory: one entry, registered read, valid bit stands for its zero reset
	state_t state_mem [1];
	state_t rd_s1;
	state_t wr_q;
	logic   mem_valid_q;
	state_t st_cur;
	state_t st_next;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= state_mem[0];
		end
		if (valid_s1) begin
			state_mem[0] <= st_next;
			wr_q         <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_valid_q <= 1'b0;
		end else if (valid_s1) begin
			mem_valid_q <= 1'b1;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			st_cur = wr_q;
		end else if (mem_valid_q) begin
			st_cur = rd_s1;
		end else begin
			st_cur = '0;
		end
	end

	// step logic
	result_t    res0;
	result_t    res1;
	result_t    code_res;
	logic [7:0] hit;
	logic [1:0] gap_eff;
	logic [1:0] gap_inc;
	logic       has_code;
	logic       is_elem;
	logic       space;

	always_comb begin
		hit      = morse_lookup(4'(st_cur.len), 8'(st_cur.bits));
		has_code = st_cur.len != '0;
		is_elem  = char_s1 inside {CHAR_DOT, CHAR_DASH};
		gap_eff  = (word_gap_q == 2'd0) ? 2'd1 : word_gap_q;
		gap_inc  = st_cur.gap + 2'd1;
		space    = gap_inc >= gap_eff;

		code_res.ch   = (hit[7] && !st_cur.ovf) ? hit[6:0] : CHAR_NONE;
		code_res.unk  = !(hit[7] && !st_cur.ovf);
		code_res.last = 1'b0;

		res0    = code_res;
		res1    = '{ch: CHAR_NL, unk: 1'b0, last: 1'b1};
		n_res   = 2'd0;
		st_next = st_cur;

		if (eom_s1) begin
			// flush pending word, then newline; clear everything
			st_next = '0;
			if (has_code) begin
				n_res = 2'd2;
			end else begin
				res0  = '{ch: CHAR_NL, unk: 1'b0, last: 1'b1};
				n_res = 2'd1;
			end
		end else if (is_elem) begin
			if (st_cur.len < LEN_W'(MAX_CODE_LEN)) begin
				st_next.bits = {st_cur.bits[MAX_CODE_LEN-2:0], char_s1 == CHAR_DASH};
				st_next.len  = st_cur.len + LEN_W'(1);
			end else begin
				// drop extra elements, mark the word too long
				st_next.ovf = 1'b1;
			end
			st_next.gap = 2'd0;
		end else begin
			if (has_code) begin
				st_next.bits = '0;
				st_next.len  = '0;
				st_next.ovf  = 1'b0;
			end
			st_next.gap = space ? 2'd0 : gap_inc;
			res1 = '{ch: CHAR_SPACE, unk: 1'b0, last: 1'b1};
			if (has_code && space) begin
				n_res = 2'd2;
			end else if (has_code) begin
				res0.last = 1'b1;
				n_res     = 2'd1;
			end else if (space) begin
				res0  = res1;
				n_res = 2'd1;
			end
		end
	end

	assign push_n = valid_s1 ? n_res : 2'd0;

	msd_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.push0  (res0),
		.push1  (res1),
		.level  (level),
		.out_ch (out_ch)
	);
endmodule

[rtl/msd_checker.sv]
// Checker: port-level assertions on the stream decoder, bound to its top level.
`timescale 1ns / 1ps
module msd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_char,
	input logic       unknown_code,
	input logic       last_of_run
);
	import msd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char)
			&& $stable(unknown_code) && $stable(last_of_run))
		else $error("result changed while stalled");

	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_char == CHAR_NL |-> last_of_run && !unknown_code)
		else $error("newline not final or flagged unknown");

	a_space_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_char == CHAR_SPACE |-> last_of_run && !unknown_code)
		else $error("word space not final or flagged unknown");

	a_unk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unknown_code |-> out_char == CHAR_NONE)
		else $error("unknown code with nonzero character");
endmodule

bind morse_stream_decoder_unit msd_checker u_msd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_char     (out_ch.out_char),
	.unknown_code (out_ch.unknown_code),
	.last_of_run  (out_ch.last_of_run)
);
